// ===== rtl/dpdd_pkg.sv =====
// ----------------------------------------------------------------------------
// dpdd_pkg: shared definitions for the dual PID differential drive block
// Field widths, register indexes and reset values, loop limits, the
// sequencer state type and the truncating divide by 256.
// ----------------------------------------------------------------------------
package dpdd_pkg;

	// Beat field widths
	localparam int CNT_W  = 11;
	localparam int OFS_W  = 9;
	localparam int DUTY_W = 14;
	localparam int SCMD_W = 13;
	localparam int TCMD_W = 8;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int TGT_W      = 16;
	localparam int GAIN_W     = 12;
	localparam int LIM_W      = 14;

	localparam logic [CFG_IDX_W-1:0] REG_TARGET_SPEED = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_KP     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_KI     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_KD     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STEER_KP     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_STEER_KI     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_STEER_KD     = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_OUTPUT   = 3'd7;

	localparam logic [TGT_W-1:0]  RST_TARGET_SPEED = 16'd3300;
	localparam logic [GAIN_W-1:0] RST_SPEED_KP     = 12'd307;
	localparam logic [GAIN_W-1:0] RST_SPEED_KI     = 12'd51;
	localparam logic [GAIN_W-1:0] RST_SPEED_KD     = 12'd256;
	localparam logic [GAIN_W-1:0] RST_STEER_KP     = 12'd333;
	localparam logic [GAIN_W-1:0] RST_STEER_KI     = 12'd205;
	localparam logic [GAIN_W-1:0] RST_STEER_KD     = 12'd1280;
	localparam logic [LIM_W-1:0]  RST_MAX_OUTPUT   = 14'd6000;

	// Mixer defaults
	localparam int STEER_SPAN_DEF = 200;
	localparam int RIGHT_TRIM_DEF = 900;

	// Loop constants
	localparam int SPEED_SCALE = 40;
	localparam int BLEND_NEW   = 230;
	localparam int BLEND_OLD   = 26;
	localparam int SPD_INT_LIM = 300;
	localparam int SPD_CMD_LIM = 4000;
	localparam int STR_INT_LIM = 40;
	localparam int STR_CMD_LIM = 80;
	localparam int DEAD_ZONE   = 2;

	// Datapath widths
	localparam int ACC_W       = 32;
	localparam int MUL_W       = 26;
	localparam int PROD_W      = 2 * MUL_W;
	localparam int MAG_W       = 23;
	localparam int RECIP_W     = 25;
	localparam int RECIP_SHIFT = 24;
	localparam int SIDE_W      = 25;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_SPD_NEW,
		ST_SPD_OLD,
		ST_SPD_SUM,
		ST_SPD_ERR,
		ST_SPD_INT,
		ST_SPD_KI,
		ST_SPD_KD,
		ST_STR_NEW,
		ST_SPD_CMD,
		ST_STR_SUM,
		ST_STR_ERR,
		ST_STR_INT,
		ST_STR_KI,
		ST_STR_KD,
		ST_STR_SUM2,
		ST_STR_CMD,
		ST_MIX_L,
		ST_MIX_R,
		ST_REC_L,
		ST_REC_R,
		ST_BACK_L,
		ST_BACK_R,
		ST_FIX_R,
		ST_DONE
	} state_t;

	// Divide by 256, truncating toward zero
	function automatic logic signed [ACC_W-1:0] tdiv256(input logic signed [ACC_W-1:0] x);
		logic signed [ACC_W-1:0] bias;
		bias = x[ACC_W-1] ? ACC_W'(255) : ACC_W'(0);
		return (x + bias) >>> 8;
	endfunction

endpackage

// ===== rtl/dpdd_stream_if.sv =====
// ----------------------------------------------------------------------------
// dpdd_stream_if: valid/ready channels of the dual PID differential drive
// dpdd_sensor_if carries one control tick in, dpdd_drive_if one result out.
// ----------------------------------------------------------------------------
interface dpdd_sensor_if;
	logic                              valid;
	logic                              ready;
	logic signed [dpdd_pkg::CNT_W-1:0] encoder_count;
	logic signed [dpdd_pkg::OFS_W-1:0] lateral_offset;

	modport source(output valid, encoder_count, lateral_offset, input ready);
	modport sink(input valid, encoder_count, lateral_offset, output ready);
endinterface

interface dpdd_drive_if;
	logic                               valid;
	logic                               ready;
	logic        [dpdd_pkg::DUTY_W-1:0] left_duty;
	logic                               left_reverse;
	logic        [dpdd_pkg::DUTY_W-1:0] right_duty;
	logic                               right_reverse;
	logic signed [dpdd_pkg::SCMD_W-1:0] speed_command;
	logic signed [dpdd_pkg::TCMD_W-1:0] steer_command;

	modport source(output valid, left_duty, left_reverse, right_duty, right_reverse,
		speed_command, steer_command, input ready);
	modport sink(input valid, left_duty, left_reverse, right_duty, right_reverse,
		speed_command, steer_command, output ready);
endinterface

// ===== rtl/dual_pid_differential_drive.sv =====
// ----------------------------------------------------------------------------
// dual_pid_differential_drive: speed and steering PID with a two-wheel mixer
// One sensor beat per control tick in, one drive beat per tick out.
// ----------------------------------------------------------------------------
// Each sensor beat (encoder count, lateral offset) runs through a speed PID and
// a steering PID, and a mixer turns both commands into a duty and a reverse
// flag for each wheel. All products go through one shared 26x26 multiplier
// under a 25-state sequencer: one beat holds the block from acceptance until
// the result sits in the output register, and the next sensor beat is taken
// only once the sequencer is back in ST_IDLE, so a new tick is never taken
// before the last one is through. The output register lets a new tick start
// while the previous result still waits; a tick only stalls in its last step
// if that earlier result has not been taken yet. Configuration writes are
// registered and should only be issued while the block is idle.
// ----------------------------------------------------------------------------
module dual_pid_differential_drive #(
	parameter int STEER_SPAN = dpdd_pkg::STEER_SPAN_DEF,
	parameter int RIGHT_TRIM = dpdd_pkg::RIGHT_TRIM_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [dpdd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [dpdd_pkg::CFG_DATA_W-1:0]     cfg_data,
	dpdd_sensor_if.sink                         sensor,
	dpdd_drive_if.source                        drive
);

	// Mixer constants. Left and right values are divided by the span through a
	// fixed-point reciprocal; one compare-and-bump fixes the floor error.
	localparam logic signed [11:0] SPAN_S = 12'(STEER_SPAN);
	localparam logic [dpdd_pkg::MAG_W-1:0] SPAN_MAG = dpdd_pkg::MAG_W'(STEER_SPAN);
	localparam logic [dpdd_pkg::RECIP_W-1:0] RECIP =
		dpdd_pkg::RECIP_W'((64'd1 << dpdd_pkg::RECIP_SHIFT) / STEER_SPAN);
	localparam logic signed [dpdd_pkg::SIDE_W-1:0] TRIM_S = dpdd_pkg::SIDE_W'(RIGHT_TRIM);

	// Sequencer
	dpdd_pkg::state_t state_q, state_d;
	logic sensor_ready;
	logic out_load;

	// Configuration registers
	logic [dpdd_pkg::TGT_W-1:0]  target_q;
	logic [dpdd_pkg::GAIN_W-1:0] spd_kp_q, spd_ki_q, spd_kd_q;
	logic [dpdd_pkg::GAIN_W-1:0] str_kp_q, str_ki_q, str_kd_q;
	logic [dpdd_pkg::LIM_W-1:0]  lim_q;

	// Loop history, kept across ticks
	logic signed [16:0] prev_raw_q;
	logic signed [9:0]  spd_int_q;
	logic signed [17:0] prev_serr_q;
	logic signed [9:0]  prev_terr_q;
	logic signed [6:0]  str_int_q;

	// Per-tick working registers
	logic signed [16:0] raw_q;
	logic signed [dpdd_pkg::OFS_W-1:0] ofs_q;
	logic signed [dpdd_pkg::ACC_W-1:0] acc_q;
	logic signed [dpdd_pkg::PROD_W-1:0] prod_q;
	logic signed [17:0] serr_q;
	logic signed [18:0] sd_q;
	logic signed [9:0]  terr_q;
	logic signed [10:0] td_q;
	logic signed [dpdd_pkg::SCMD_W-1:0] scmd_q;
	logic signed [dpdd_pkg::TCMD_W-1:0] tcmd_q;
	logic [dpdd_pkg::MAG_W-1:0] mag_l_q, mag_r_q, quo_l_q, quo_r_q;
	logic neg_l_q, neg_r_q;

	// Output register
	logic out_valid_q;
	logic [dpdd_pkg::DUTY_W-1:0] left_duty_q, right_duty_q;
	logic left_rev_q, right_rev_q;
	logic signed [dpdd_pkg::SCMD_W-1:0] speed_cmd_q;
	logic signed [dpdd_pkg::TCMD_W-1:0] steer_cmd_q;

	// Shared arithmetic
	logic signed [dpdd_pkg::MUL_W-1:0] mul_a, mul_b;
	logic signed [dpdd_pkg::ACC_W-1:0] prod_lo, acc_sum, acc_div;
	logic signed [18:0] spd_int_sum;
	logic signed [10:0] str_int_sum;
	logic signed [24:0] prod_mix;
	logic [dpdd_pkg::MAG_W-1:0] prod_mag, rem_base, rem;
	logic rem_big;
	logic signed [dpdd_pkg::SIDE_W-1:0] lim_s, left_v, right_v, left_c, right_c;

	function automatic logic signed [dpdd_pkg::SIDE_W-1:0] clamp_side(
		input logic signed [dpdd_pkg::SIDE_W-1:0] v,
		input logic signed [dpdd_pkg::SIDE_W-1:0] lim
	);
		if (v > lim) begin
			return lim;
		end else if (v < -lim) begin
			return -lim;
		end
		return v;
	endfunction

	assign prod_lo     = prod_q[dpdd_pkg::ACC_W-1:0];
	assign acc_sum     = acc_q + prod_lo;
	assign acc_div     = dpdd_pkg::tdiv256(acc_q);
	assign spd_int_sum = 19'(spd_int_q) + 19'(serr_q);
	assign str_int_sum = 11'(str_int_q) + 11'(terr_q);

	// Magnitude and sign of a mixer product, then the remainder check that
	// bumps a reciprocal quotient that came out one short.
	assign prod_mix = prod_q[24:0];
	assign prod_mag = prod_mix[24] ? dpdd_pkg::MAG_W'(-prod_mix) : prod_mix[dpdd_pkg::MAG_W-1:0];
	assign rem_base = (state_q == dpdd_pkg::ST_BACK_R) ? mag_l_q : mag_r_q;
	assign rem      = rem_base - prod_q[dpdd_pkg::MAG_W-1:0];
	assign rem_big  = (rem >= SPAN_MAG);

	// Side values: restore the sign, add trim on the right, saturate
	assign lim_s   = dpdd_pkg::SIDE_W'(lim_q);
	assign left_v  = neg_l_q ? -dpdd_pkg::SIDE_W'(quo_l_q) : dpdd_pkg::SIDE_W'(quo_l_q);
	assign right_v = (neg_r_q ? -dpdd_pkg::SIDE_W'(quo_r_q) : dpdd_pkg::SIDE_W'(quo_r_q))
		+ TRIM_S;
	assign left_c  = clamp_side(left_v, lim_s);
	assign right_c = clamp_side(right_v, lim_s);

	assign sensor.ready        = sensor_ready;
	assign drive.valid         = out_valid_q;
	assign drive.left_duty     = left_duty_q;
	assign drive.left_reverse  = left_rev_q;
	assign drive.right_duty    = right_duty_q;
	assign drive.right_reverse = right_rev_q;
	assign drive.speed_command = speed_cmd_q;
	assign drive.steer_command = steer_cmd_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dpdd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and multiplier operands. A step that issues a product leaves it
	// in prod_q, and the step after it consumes that product.
	always_comb begin
		state_d      = state_q;
		sensor_ready = 1'b0;
		out_load     = 1'b0;
		mul_a        = '0;
		mul_b        = '0;
		case (state_q)
			dpdd_pkg::ST_IDLE: begin
				sensor_ready = 1'b1;
				if (sensor.valid) begin
					state_d = dpdd_pkg::ST_SPD_NEW;
				end
			end
			dpdd_pkg::ST_SPD_NEW: begin
				mul_a   = dpdd_pkg::MUL_W'(raw_q);
				mul_b   = dpdd_pkg::MUL_W'(dpdd_pkg::BLEND_NEW);
				state_d = dpdd_pkg::ST_SPD_OLD;
			end
			dpdd_pkg::ST_SPD_OLD: begin
				mul_a   = dpdd_pkg::MUL_W'(prev_raw_q);
				mul_b   = dpdd_pkg::MUL_W'(dpdd_pkg::BLEND_OLD);
				state_d = dpdd_pkg::ST_SPD_SUM;
			end
			dpdd_pkg::ST_SPD_SUM: state_d = dpdd_pkg::ST_SPD_ERR;
			dpdd_pkg::ST_SPD_ERR: state_d = dpdd_pkg::ST_SPD_INT;
			dpdd_pkg::ST_SPD_INT: begin
				mul_a   = dpdd_pkg::MUL_W'(serr_q);
				mul_b   = dpdd_pkg::MUL_W'(spd_kp_q);
				state_d = dpdd_pkg::ST_SPD_KI;
			end
			dpdd_pkg::ST_SPD_KI: begin
				mul_a   = dpdd_pkg::MUL_W'(spd_int_q);
				mul_b   = dpdd_pkg::MUL_W'(spd_ki_q);
				state_d = dpdd_pkg::ST_SPD_KD;
			end
			dpdd_pkg::ST_SPD_KD: begin
				mul_a   = dpdd_pkg::MUL_W'(sd_q);
				mul_b   = dpdd_pkg::MUL_W'(spd_kd_q);
				state_d = dpdd_pkg::ST_STR_NEW;
			end
			dpdd_pkg::ST_STR_NEW: begin
				mul_a   = dpdd_pkg::MUL_W'(ofs_q);
				mul_b   = dpdd_pkg::MUL_W'(dpdd_pkg::BLEND_NEW);
				state_d = dpdd_pkg::ST_SPD_CMD;
			end
			dpdd_pkg::ST_SPD_CMD: begin
				mul_a   = dpdd_pkg::MUL_W'(prev_terr_q);
				mul_b   = dpdd_pkg::MUL_W'(dpdd_pkg::BLEND_OLD);
				state_d = dpdd_pkg::ST_STR_SUM;
			end
			dpdd_pkg::ST_STR_SUM: state_d = dpdd_pkg::ST_STR_ERR;
			dpdd_pkg::ST_STR_ERR: state_d = dpdd_pkg::ST_STR_INT;
			dpdd_pkg::ST_STR_INT: begin
				mul_a   = dpdd_pkg::MUL_W'(terr_q);
				mul_b   = dpdd_pkg::MUL_W'(str_kp_q);
				state_d = dpdd_pkg::ST_STR_KI;
			end
			dpdd_pkg::ST_STR_KI: begin
				mul_a   = dpdd_pkg::MUL_W'(str_int_q);
				mul_b   = dpdd_pkg::MUL_W'(str_ki_q);
				state_d = dpdd_pkg::ST_STR_KD;
			end
			dpdd_pkg::ST_STR_KD: begin
				mul_a   = dpdd_pkg::MUL_W'(td_q);
				mul_b   = dpdd_pkg::MUL_W'(str_kd_q);
				state_d = dpdd_pkg::ST_STR_SUM2;
			end
			dpdd_pkg::ST_STR_SUM2: state_d = dpdd_pkg::ST_STR_CMD;
			dpdd_pkg::ST_STR_CMD:  state_d = dpdd_pkg::ST_MIX_L;
			dpdd_pkg::ST_MIX_L: begin
				mul_a   = dpdd_pkg::MUL_W'(scmd_q);
				mul_b   = dpdd_pkg::MUL_W'(SPAN_S - 12'(tcmd_q));
				state_d = dpdd_pkg::ST_MIX_R;
			end
			dpdd_pkg::ST_MIX_R: begin
				mul_a   = dpdd_pkg::MUL_W'(scmd_q);
				mul_b   = dpdd_pkg::MUL_W'(SPAN_S + 12'(tcmd_q));
				state_d = dpdd_pkg::ST_REC_L;
			end
			dpdd_pkg::ST_REC_L: begin
				mul_a   = dpdd_pkg::MUL_W'(mag_l_q);
				mul_b   = dpdd_pkg::MUL_W'(RECIP);
				state_d = dpdd_pkg::ST_REC_R;
			end
			dpdd_pkg::ST_REC_R: begin
				mul_a   = dpdd_pkg::MUL_W'(mag_r_q);
				mul_b   = dpdd_pkg::MUL_W'(RECIP);
				state_d = dpdd_pkg::ST_BACK_L;
			end
			dpdd_pkg::ST_BACK_L: begin
				mul_a   = dpdd_pkg::MUL_W'(quo_l_q);
				mul_b   = dpdd_pkg::MUL_W'(SPAN_MAG);
				state_d = dpdd_pkg::ST_BACK_R;
			end
			dpdd_pkg::ST_BACK_R: begin
				mul_a   = dpdd_pkg::MUL_W'(quo_r_q);
				mul_b   = dpdd_pkg::MUL_W'(SPAN_MAG);
				state_d = dpdd_pkg::ST_FIX_R;
			end
			dpdd_pkg::ST_FIX_R: state_d = dpdd_pkg::ST_DONE;
			dpdd_pkg::ST_DONE: begin
				// Hold here until the previous result has left the output register
				if (!out_valid_q || drive.ready) begin
					out_load = 1'b1;
					state_d  = dpdd_pkg::ST_IDLE;
				end
			end
			default: state_d = dpdd_pkg::ST_IDLE;
		endcase
	end

	// Configuration, loop history and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q    <= dpdd_pkg::RST_TARGET_SPEED;
			spd_kp_q    <= dpdd_pkg::RST_SPEED_KP;
			spd_ki_q    <= dpdd_pkg::RST_SPEED_KI;
			spd_kd_q    <= dpdd_pkg::RST_SPEED_KD;
			str_kp_q    <= dpdd_pkg::RST_STEER_KP;
			str_ki_q    <= dpdd_pkg::RST_STEER_KI;
			str_kd_q    <= dpdd_pkg::RST_STEER_KD;
			lim_q       <= dpdd_pkg::RST_MAX_OUTPUT;
			prev_raw_q  <= '0;
			spd_int_q   <= '0;
			prev_serr_q <= '0;
			prev_terr_q <= '0;
			str_int_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					dpdd_pkg::REG_TARGET_SPEED: target_q <= cfg_data[dpdd_pkg::TGT_W-1:0];
					dpdd_pkg::REG_SPEED_KP:     spd_kp_q <= cfg_data[dpdd_pkg::GAIN_W-1:0];
					dpdd_pkg::REG_SPEED_KI:     spd_ki_q <= cfg_data[dpdd_pkg::GAIN_W-1:0];
					dpdd_pkg::REG_SPEED_KD:     spd_kd_q <= cfg_data[dpdd_pkg::GAIN_W-1:0];
					dpdd_pkg::REG_STEER_KP:     str_kp_q <= cfg_data[dpdd_pkg::GAIN_W-1:0];
					dpdd_pkg::REG_STEER_KI:     str_ki_q <= cfg_data[dpdd_pkg::GAIN_W-1:0];
					dpdd_pkg::REG_STEER_KD:     str_kd_q <= cfg_data[dpdd_pkg::GAIN_W-1:0];
					dpdd_pkg::REG_MAX_OUTPUT:   lim_q    <= cfg_data[dpdd_pkg::LIM_W-1:0];
					default: ;
				endcase
			end

			case (state_q)
				dpdd_pkg::ST_SPD_ERR: prev_raw_q <= raw_q;
				dpdd_pkg::ST_SPD_INT: begin
					// Add first, then clamp the integrator
					if (spd_int_sum > dpdd_pkg::SPD_INT_LIM) begin
						spd_int_q <= 10'(dpdd_pkg::SPD_INT_LIM);
					end else if (spd_int_sum < -dpdd_pkg::SPD_INT_LIM) begin
						spd_int_q <= 10'(-dpdd_pkg::SPD_INT_LIM);
					end else begin
						spd_int_q <= spd_int_sum[9:0];
					end
					prev_serr_q <= serr_q;
				end
				dpdd_pkg::ST_STR_INT: begin
					if (str_int_sum > dpdd_pkg::STR_INT_LIM) begin
						str_int_q <= 7'(dpdd_pkg::STR_INT_LIM);
					end else if (str_int_sum < -dpdd_pkg::STR_INT_LIM) begin
						str_int_q <= 7'(-dpdd_pkg::STR_INT_LIM);
					end else begin
						str_int_q <= str_int_sum[6:0];
					end
					prev_terr_q <= terr_q;
				end
				default: ;
			endcase

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (drive.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working datapath
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;

		case (state_q)
			dpdd_pkg::ST_IDLE: begin
				if (sensor.valid) begin
					raw_q <= 17'(sensor.encoder_count) * 17'(dpdd_pkg::SPEED_SCALE);
					ofs_q <= sensor.lateral_offset;
				end
			end
			dpdd_pkg::ST_SPD_OLD: acc_q <= prod_lo;
			dpdd_pkg::ST_SPD_SUM: acc_q <= acc_sum;
			dpdd_pkg::ST_SPD_ERR: begin
				serr_q <= 18'(target_q) - 18'($signed(acc_div[16:0]));
			end
			dpdd_pkg::ST_SPD_INT: sd_q  <= 19'(serr_q) - 19'(prev_serr_q);
			dpdd_pkg::ST_SPD_KI:  acc_q <= prod_lo;
			dpdd_pkg::ST_SPD_KD:  acc_q <= acc_sum;
			dpdd_pkg::ST_STR_NEW: acc_q <= acc_sum;
			dpdd_pkg::ST_SPD_CMD: begin
				if (acc_div > dpdd_pkg::SPD_CMD_LIM) begin
					scmd_q <= dpdd_pkg::SCMD_W'(dpdd_pkg::SPD_CMD_LIM);
				end else if (acc_div < -dpdd_pkg::SPD_CMD_LIM) begin
					scmd_q <= dpdd_pkg::SCMD_W'(-dpdd_pkg::SPD_CMD_LIM);
				end else begin
					scmd_q <= acc_div[dpdd_pkg::SCMD_W-1:0];
				end
				acc_q <= prod_lo;
			end
			dpdd_pkg::ST_STR_SUM: acc_q <= acc_sum;
			dpdd_pkg::ST_STR_ERR: begin
				// Dead zone: small filtered errors count as zero
				if (acc_div < dpdd_pkg::DEAD_ZONE && acc_div > -dpdd_pkg::DEAD_ZONE) begin
					terr_q <= '0;
				end else begin
					terr_q <= acc_div[9:0];
				end
			end
			dpdd_pkg::ST_STR_INT:  td_q  <= 11'(terr_q) - 11'(prev_terr_q);
			dpdd_pkg::ST_STR_KI:   acc_q <= prod_lo;
			dpdd_pkg::ST_STR_KD:   acc_q <= acc_sum;
			dpdd_pkg::ST_STR_SUM2: acc_q <= acc_sum;
			dpdd_pkg::ST_STR_CMD: begin
				if (acc_div > dpdd_pkg::STR_CMD_LIM) begin
					tcmd_q <= dpdd_pkg::TCMD_W'(dpdd_pkg::STR_CMD_LIM);
				end else if (acc_div < -dpdd_pkg::STR_CMD_LIM) begin
					tcmd_q <= dpdd_pkg::TCMD_W'(-dpdd_pkg::STR_CMD_LIM);
				end else begin
					tcmd_q <= acc_div[dpdd_pkg::TCMD_W-1:0];
				end
			end
			dpdd_pkg::ST_MIX_R: begin
				mag_l_q <= prod_mag;
				neg_l_q <= prod_q[dpdd_pkg::PROD_W-1];
			end
			dpdd_pkg::ST_REC_L: begin
				mag_r_q <= prod_mag;
				neg_r_q <= prod_q[dpdd_pkg::PROD_W-1];
			end
			dpdd_pkg::ST_REC_R:  quo_l_q <= prod_q[dpdd_pkg::RECIP_SHIFT +: dpdd_pkg::MAG_W];
			dpdd_pkg::ST_BACK_L: quo_r_q <= prod_q[dpdd_pkg::RECIP_SHIFT +: dpdd_pkg::MAG_W];
			dpdd_pkg::ST_BACK_R: begin
				if (rem_big) begin
					quo_l_q <= quo_l_q + dpdd_pkg::MAG_W'(1);
				end
			end
			dpdd_pkg::ST_FIX_R: begin
				if (rem_big) begin
					quo_r_q <= quo_r_q + dpdd_pkg::MAG_W'(1);
				end
			end
			default: ;
		endcase

		if (out_load) begin
			left_duty_q  <= left_c[dpdd_pkg::SIDE_W-1] ? dpdd_pkg::DUTY_W'(-left_c)
				: left_c[dpdd_pkg::DUTY_W-1:0];
			left_rev_q   <= left_c[dpdd_pkg::SIDE_W-1] || (left_c == '0);
			right_duty_q <= right_c[dpdd_pkg::SIDE_W-1] ? dpdd_pkg::DUTY_W'(-right_c)
				: right_c[dpdd_pkg::DUTY_W-1:0];
			right_rev_q  <= right_c[dpdd_pkg::SIDE_W-1] || (right_c == '0);
			speed_cmd_q  <= scmd_q;
			steer_cmd_q  <= tcmd_q;
		end
	end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the dual PID differential drive
// Drives sensor beats through valid/ready with random gaps and output stalls,
// sweeps the configuration registers between phases, and checks each drive
// beat field by field against a cycle-free model of both PID loops and the
// wheel mixer.
// ----------------------------------------------------------------------------
module testbench;

	// Mixer parameters as the block is built here
	localparam int STEER_SPAN = dpdd_pkg::STEER_SPAN_DEF;
	localparam int RIGHT_TRIM = dpdd_pkg::RIGHT_TRIM_DEF;

	// Run shape: a directed warm-up, then phases of random ticks
	localparam int PHASES          = 11;
	localparam int TICKS_PER_PHASE = 110;
	localparam int DRAIN_CYCLES    = 40;
	localparam int REG_COUNT       = 1 << dpdd_pkg::CFG_IDX_W;

	localparam int CNT_MAX = (1 << (dpdd_pkg::CNT_W - 1)) - 1;
	localparam int CNT_MIN = -(1 << (dpdd_pkg::CNT_W - 1));
	localparam int OFS_MAX = (1 << (dpdd_pkg::OFS_W - 1)) - 1;
	localparam int OFS_MIN = -(1 << (dpdd_pkg::OFS_W - 1));

	typedef struct packed {
		logic [dpdd_pkg::DUTY_W-1:0]        left_duty;
		logic                               left_reverse;
		logic [dpdd_pkg::DUTY_W-1:0]        right_duty;
		logic                               right_reverse;
		logic signed [dpdd_pkg::SCMD_W-1:0] speed_command;
		logic signed [dpdd_pkg::TCMD_W-1:0] steer_command;
	} drive_t;

	// ------------------------------------------------------------------------
	// Scoreboard: holds a copy of the registers and loop state, predicts the
	// drive beat for every accepted sensor beat and checks results in order.
	// ------------------------------------------------------------------------
	class drive_scoreboard;
		logic [dpdd_pkg::TGT_W-1:0]  target_speed;
		logic [dpdd_pkg::GAIN_W-1:0] spd_kp, spd_ki, spd_kd;
		logic [dpdd_pkg::GAIN_W-1:0] str_kp, str_ki, str_kd;
		logic [dpdd_pkg::LIM_W-1:0]  duty_limit;
		logic signed [16:0]          last_raw_speed;
		logic signed [9:0]           speed_acc;
		logic signed [17:0]          last_speed_err;
		logic signed [15:0]          last_steer_err;
		logic signed [15:0]          steer_acc;
		drive_t                      expected_drive[$];
		int                          results_seen;
		int                          mismatches;

		function new();
			target_speed   = dpdd_pkg::RST_TARGET_SPEED;
			spd_kp         = dpdd_pkg::RST_SPEED_KP;
			spd_ki         = dpdd_pkg::RST_SPEED_KI;
			spd_kd         = dpdd_pkg::RST_SPEED_KD;
			str_kp         = dpdd_pkg::RST_STEER_KP;
			str_ki         = dpdd_pkg::RST_STEER_KI;
			str_kd         = dpdd_pkg::RST_STEER_KD;
			duty_limit     = dpdd_pkg::RST_MAX_OUTPUT;
			last_raw_speed = '0;
			speed_acc      = '0;
			last_speed_err = '0;
			last_steer_err = '0;
			steer_acc      = '0;
			results_seen   = 0;
			mismatches     = 0;
		endfunction

		function void set_register(int idx, logic [dpdd_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				dpdd_pkg::REG_TARGET_SPEED: target_speed = data[dpdd_pkg::TGT_W-1:0];
				dpdd_pkg::REG_SPEED_KP:     spd_kp       = data[dpdd_pkg::GAIN_W-1:0];
				dpdd_pkg::REG_SPEED_KI:     spd_ki       = data[dpdd_pkg::GAIN_W-1:0];
				dpdd_pkg::REG_SPEED_KD:     spd_kd       = data[dpdd_pkg::GAIN_W-1:0];
				dpdd_pkg::REG_STEER_KP:     str_kp       = data[dpdd_pkg::GAIN_W-1:0];
				dpdd_pkg::REG_STEER_KI:     str_ki       = data[dpdd_pkg::GAIN_W-1:0];
				dpdd_pkg::REG_STEER_KD:     str_kd       = data[dpdd_pkg::GAIN_W-1:0];
				dpdd_pkg::REG_MAX_OUTPUT:   duty_limit   = data[dpdd_pkg::LIM_W-1:0];
				default: ;
			endcase
		endfunction

		function longint clamp(longint v, longint lim);
			return v < -lim ? -lim : (v > lim ? lim : v);
		endfunction

		// One control tick; division on longint truncates toward zero
		function drive_t predict_drive(logic signed [dpdd_pkg::CNT_W-1:0] count,
				logic signed [dpdd_pkg::OFS_W-1:0] offset);
			longint raw, filt, serr, scmd, terr, tcmd, lv, rv;
			drive_t d;
			raw  = longint'(count) * dpdd_pkg::SPEED_SCALE;
			filt = (dpdd_pkg::BLEND_NEW * raw
				+ dpdd_pkg::BLEND_OLD * longint'(last_raw_speed)) / 256;
			last_raw_speed = 17'(raw);
			serr = longint'(target_speed) - filt;
			speed_acc = 10'(clamp(longint'(speed_acc) + serr, dpdd_pkg::SPD_INT_LIM));
			scmd = (longint'(spd_kp) * serr + longint'(spd_ki) * longint'(speed_acc)
				+ longint'(spd_kd) * (serr - longint'(last_speed_err))) / 256;
			last_speed_err = 18'(serr);
			scmd = clamp(scmd, dpdd_pkg::SPD_CMD_LIM);

			terr = (dpdd_pkg::BLEND_NEW * longint'(offset)
				+ dpdd_pkg::BLEND_OLD * longint'(last_steer_err)) / 256;
			if (terr < dpdd_pkg::DEAD_ZONE && terr > -dpdd_pkg::DEAD_ZONE)
				terr = 0;
			steer_acc = 16'(clamp(longint'(steer_acc) + terr, dpdd_pkg::STR_INT_LIM));
			tcmd = (longint'(str_kp) * terr + longint'(str_ki) * longint'(steer_acc)
				+ longint'(str_kd) * (terr - longint'(last_steer_err))) / 256;
			last_steer_err = 16'(terr);
			tcmd = clamp(tcmd, dpdd_pkg::STR_CMD_LIM);

			lv = clamp(scmd * (STEER_SPAN - tcmd) / STEER_SPAN, longint'(duty_limit));
			rv = clamp(scmd * (STEER_SPAN + tcmd) / STEER_SPAN + RIGHT_TRIM,
				longint'(duty_limit));

			d.left_duty     = dpdd_pkg::DUTY_W'(lv > 0 ? lv : -lv);
			d.left_reverse  = (lv <= 0);
			d.right_duty    = dpdd_pkg::DUTY_W'(rv > 0 ? rv : -rv);
			d.right_reverse = (rv <= 0);
			d.speed_command = dpdd_pkg::SCMD_W'(scmd);
			d.steer_command = dpdd_pkg::TCMD_W'(tcmd);
			return d;
		endfunction

		function void note_tick(logic signed [dpdd_pkg::CNT_W-1:0] count,
				logic signed [dpdd_pkg::OFS_W-1:0] offset);
			expected_drive.push_back(predict_drive(count, offset));
		endfunction

		task report_mismatch(string msg);
			$display("[%0t] result %0d: %s", $realtime, results_seen, msg);
			mismatches++;
		endtask

		task check_drive(drive_t got);
			drive_t want;
			results_seen++;
			if (expected_drive.size() == 0) begin
				report_mismatch("drive beat arrived with nothing expected");
				return;
			end
			want = expected_drive.pop_front();
			if (got.left_duty !== want.left_duty)
				report_mismatch($sformatf("left_duty expected %0d got %0d",
					want.left_duty, got.left_duty));
			if (got.left_reverse !== want.left_reverse)
				report_mismatch($sformatf("left_reverse expected %0b got %0b",
					want.left_reverse, got.left_reverse));
			if (got.right_duty !== want.right_duty)
				report_mismatch($sformatf("right_duty expected %0d got %0d",
					want.right_duty, got.right_duty));
			if (got.right_reverse !== want.right_reverse)
				report_mismatch($sformatf("right_reverse expected %0b got %0b",
					want.right_reverse, got.right_reverse));
			if (got.speed_command !== want.speed_command)
				report_mismatch($sformatf("speed_command expected %0d got %0d",
					want.speed_command, got.speed_command));
			if (got.steer_command !== want.steer_command)
				report_mismatch($sformatf("steer_command expected %0d got %0d",
					want.steer_command, got.steer_command));
		endtask

		task check_drained();
			if (expected_drive.size() != 0)
				report_mismatch($sformatf("%0d drive beats never arrived",
					expected_drive.size()));
		endtask
	endclass

	// ------------------------------------------------------------------------
	// Clock, reset, channels and the block
	// ------------------------------------------------------------------------
	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [dpdd_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [dpdd_pkg::CFG_DATA_W-1:0] cfg_data;

	// Set for the closing phase: no gaps and no stalls from then on
	bit calm = 1'b0;

	logic [dpdd_pkg::CFG_DATA_W-1:0] next_regs [REG_COUNT];

	drive_scoreboard sb = new();

	dpdd_sensor_if sensor_ch();
	dpdd_drive_if  drive_ch();

	dual_pid_differential_drive dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sensor    (sensor_ch),
		.drive     (drive_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Monitor: sample both handshakes at the rising edge. Inputs only move on
	// the falling edge, so the values seen here are the ones the block takes.
	// Check the outgoing beat before noting the incoming one; a result can
	// never belong to the tick accepted on the same edge.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		drive_t seen;
		if (arst_n) begin
			if (drive_ch.valid && drive_ch.ready) begin
				seen.left_duty     = drive_ch.left_duty;
				seen.left_reverse  = drive_ch.left_reverse;
				seen.right_duty    = drive_ch.right_duty;
				seen.right_reverse = drive_ch.right_reverse;
				seen.speed_command = drive_ch.speed_command;
				seen.steer_command = drive_ch.steer_command;
				sb.check_drive(seen);
			end
			if (sensor_ch.valid && sensor_ch.ready)
				sb.note_tick(sensor_ch.encoder_count, sensor_ch.lateral_offset);
		end
	end

	// ------------------------------------------------------------------------
	// Drive side sink: hold ready low for random bursts, leave it high
	// otherwise; in the closing phase never stall.
	// ------------------------------------------------------------------------
	initial begin
		drive_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				drive_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(negedge clk);
			end
			drive_ch.ready <= 1'b1;
		end
	end

	// Offer one sensor beat, maybe after a gap, and hold it until taken.
	// Return on the falling edge after the accepting edge with valid still up,
	// so back-to-back beats never drop valid in between.
	task automatic send_tick(input logic signed [dpdd_pkg::CNT_W-1:0] count,
			input logic signed [dpdd_pkg::OFS_W-1:0] offset);
		if (!calm && $urandom_range(0, 4) == 0) begin
			sensor_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		sensor_ch.valid          <= 1'b1;
		sensor_ch.encoder_count  <= count;
		sensor_ch.lateral_offset <= offset;
		@(posedge clk);
		while (!sensor_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Write every register from next_regs, one per cycle, and mirror each
	// write in the scoreboard. Only called while the block is idle.
	task automatic load_settings();
		for (int i = 0; i < REG_COUNT; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= i[dpdd_pkg::CFG_IDX_W-1:0];
			cfg_data  <= next_regs[i];
			@(negedge clk);
			sb.set_register(i, next_regs[i]);
		end
		cfg_we <= 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// Directed ticks at reset settings: field extremes, the steering dead zone
	// edges (offsets that filter to -1, 0, 1 and just outside), a steady
	// cruise near the set point and hard reversals to swing the derivative.
	// ------------------------------------------------------------------------
	int dir_count [20] = '{0, CNT_MAX, CNT_MIN, CNT_MAX, CNT_MIN, 0, 0, 0, 0, 0,
		0, 82, 82, 82, 82, -1, 512, -512, CNT_MAX, 0};
	int dir_offset [20] = '{0, OFS_MAX, OFS_MIN, OFS_MIN, OFS_MAX, 1, -1, 2, -2, 3,
		-3, 0, 5, -5, 0, -1, 128, -128, 0, 0};

	initial begin
		int cnt, ofs, pick;
		int walk_count, walk_offset;

		// Known values on every input before and during reset
		arst_n                   = 1'b0;
		cfg_we                   = 1'b0;
		cfg_index                = '0;
		cfg_data                 = '0;
		sensor_ch.valid          = 1'b0;
		sensor_ch.encoder_count  = '0;
		sensor_ch.lateral_offset = '0;
		walk_count               = 0;
		walk_offset              = 0;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_count[i])
			send_tick(dpdd_pkg::CNT_W'(dir_count[i]), dpdd_pkg::OFS_W'(dir_offset[i]));

		for (int p = 1; p <= PHASES; p++) begin
			// Drop valid and let every outstanding beat come back before
			// touching the registers
			sensor_ch.valid <= 1'b0;
			while (sb.expected_drive.size() != 0)
				@(negedge clk);
			calm = (p == PHASES);

			case (p)
				// Everything at its top: raw 16-bit writes, upper bits masked
				1: foreach (next_regs[r]) next_regs[r] = '1;
				// Everything at zero: zero speed command, zero duty limit
				2: foreach (next_regs[r]) next_regs[r] = '0;
				// Close out on the reset settings
				PHASES: begin
					next_regs[dpdd_pkg::REG_TARGET_SPEED] =
						dpdd_pkg::CFG_DATA_W'(dpdd_pkg::RST_TARGET_SPEED);
					next_regs[dpdd_pkg::REG_SPEED_KP] =
						dpdd_pkg::CFG_DATA_W'(dpdd_pkg::RST_SPEED_KP);
					next_regs[dpdd_pkg::REG_SPEED_KI] =
						dpdd_pkg::CFG_DATA_W'(dpdd_pkg::RST_SPEED_KI);
					next_regs[dpdd_pkg::REG_SPEED_KD] =
						dpdd_pkg::CFG_DATA_W'(dpdd_pkg::RST_SPEED_KD);
					next_regs[dpdd_pkg::REG_STEER_KP] =
						dpdd_pkg::CFG_DATA_W'(dpdd_pkg::RST_STEER_KP);
					next_regs[dpdd_pkg::REG_STEER_KI] =
						dpdd_pkg::CFG_DATA_W'(dpdd_pkg::RST_STEER_KI);
					next_regs[dpdd_pkg::REG_STEER_KD] =
						dpdd_pkg::CFG_DATA_W'(dpdd_pkg::RST_STEER_KD);
					next_regs[dpdd_pkg::REG_MAX_OUTPUT] =
						dpdd_pkg::CFG_DATA_W'(dpdd_pkg::RST_MAX_OUTPUT);
				end
				default: begin
					// Mostly tame gains so the loops are not pinned at their
					// limits, with an occasional full-width junk write
					next_regs[dpdd_pkg::REG_TARGET_SPEED] =
						dpdd_pkg::CFG_DATA_W'($urandom_range(0, 40000));
					for (int r = dpdd_pkg::REG_SPEED_KP; r <= dpdd_pkg::REG_STEER_KD; r++)
						next_regs[r] = dpdd_pkg::CFG_DATA_W'($urandom_range(0, 1024));
					next_regs[dpdd_pkg::REG_MAX_OUTPUT] =
						dpdd_pkg::CFG_DATA_W'($urandom_range(0, 10000));
					foreach (next_regs[r])
						if ($urandom_range(0, 5) == 0)
							next_regs[r] = dpdd_pkg::CFG_DATA_W'($urandom);
				end
			endcase
			load_settings();

			for (int k = 0; k < TICKS_PER_PHASE; k++) begin
				pick = $urandom_range(0, 99);
				if (pick < 20) begin
					// Anything the fields allow
					cnt = int'($urandom_range(0, 2 * CNT_MAX + 1)) + CNT_MIN;
					ofs = int'($urandom_range(0, 2 * OFS_MAX + 1)) + OFS_MIN;
				end else if (pick < 55) begin
					// Cruise near the set point with small steering noise,
					// keeping the integrators off their rails
					cnt = int'(sb.target_speed / dpdd_pkg::SPEED_SCALE)
						+ int'($urandom_range(0, 16)) - 8;
					ofs = int'($urandom_range(0, 8)) - 4;
				end else if (pick < 90) begin
					// Slow drift from the previous tick
					cnt = walk_count + int'($urandom_range(0, 32)) - 16;
					ofs = walk_offset + int'($urandom_range(0, 16)) - 8;
				end else begin
					// Slam to a corner
					cnt = $urandom_range(0, 1) ? CNT_MAX : CNT_MIN;
					ofs = $urandom_range(0, 1) ? OFS_MAX : OFS_MIN;
				end
				cnt = cnt > CNT_MAX ? CNT_MAX : (cnt < CNT_MIN ? CNT_MIN : cnt);
				ofs = ofs > OFS_MAX ? OFS_MAX : (ofs < OFS_MIN ? OFS_MIN : ofs);
				walk_count  = cnt;
				walk_offset = ofs;
				send_tick(dpdd_pkg::CNT_W'(cnt), dpdd_pkg::OFS_W'(ofs));
			end
		end

		// Drain: wait for every result, then a little past the block's latency
		// to catch anything extra
		sensor_ch.valid <= 1'b0;
		while (sb.expected_drive.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		sb.check_drained();

		if (sb.mismatches == 0)
			$display("dual_pid_differential_drive: match");
		else
			$display("dual_pid_differential_drive: mismatch");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("dual_pid_differential_drive: mismatch");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/dpdd_pkg.sv
rtl/dpdd_stream_if.sv
rtl/dual_pid_differential_drive.sv
verif/testbench.sv
